// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

	// screen geometry
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	// fixed field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;
	localparam int IDX_W  = 11;

	localparam logic [CHAR_W-1:0] NEWLINE     = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h0F;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	// one memory access slot: one write and one read per cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
		logic [CELL_W-1:0] read_cell;
	} res_t;

endpackage

// ===== rtl/core/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
module tcw_screen_ram (
	input  logic                                clk,
	input  tcw_pkg::ram_req_t                   req,
	output logic [tcw_pkg::CELL_W-1:0]          rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/core/tcw_seq.sv =====
`timescale 1ns / 1ps
module tcw_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tcw_pkg::CHAR_W-1:0]        text_color,
	input  logic                              in_acc,
	input  logic [1:0]                        req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::IDX_W-1:0]         cell_index,
	output logic                              idle,
	output tcw_pkg::ram_req_t                 ram_req,
	input  logic [tcw_pkg::CELL_W-1:0]        rd_data,
	output logic                              res_valid,
	input  logic                              res_take,
	output tcw_pkg::res_t                     res
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam logic [AW-1:0] COLS_A = AW'(tcw_pkg::COLS);
	localparam logic [AW-1:0] LAST_A = AW'(tcw_pkg::CELLS - 1);
	localparam logic [AW-1:0] TAIL_A = AW'(tcw_pkg::CELLS - tcw_pkg::COLS);

	typedef enum logic [4:0] {
		S_FILL = 5'b00001,
		S_IDLE = 5'b00010,
		S_COPY = 5'b00100,
		S_READ = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                     state_q;
	logic                       init_q;
	logic [AW-1:0]              cnt_q;
	logic [tcw_pkg::CHAR_W-1:0] fill_color_q;
	logic [CW-1:0]              cur_col_q;
	logic [RW-1:0]              cur_row_q;
	logic                       scrolled_q;
	logic [tcw_pkg::CELL_W-1:0] rd_q;
	logic                       cp_vld_s1;
	logic [AW-1:0]              cp_addr_s1;

	logic [AW-1:0]              cur_pos;
	logic                       is_nl;
	logic                       idx_ok;
	logic [CW:0]                col_inc;
	logic [RW:0]                row_inc;
	logic [RW:0]                row_n;
	logic [CW-1:0]              put_col;
	logic [RW-1:0]              put_row;
	logic                       put_scroll;

	assign cur_pos = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
	assign is_nl   = (char_code == tcw_pkg::NEWLINE);
	assign idx_ok  = (32'(cell_index) < tcw_pkg::CELLS);
	assign col_inc = {1'b0, cur_col_q} + (CW+1)'(1);
	assign row_inc = {1'b0, cur_row_q} + (RW+1)'(1);

	// cursor step for a put
	always_comb begin
		if (is_nl || col_inc == (CW+1)'(tcw_pkg::COLS)) begin
			put_col = '0;
			row_n   = row_inc;
		end else begin
			put_col = col_inc[CW-1:0];
			row_n   = {1'b0, cur_row_q};
		end
		put_scroll = (row_n == (RW+1)'(tcw_pkg::ROWS));
		put_row    = put_scroll ? RW'(tcw_pkg::ROWS - 1) : row_n[RW-1:0];
	end

	// memory port: copy write-back wins over fill, fill stalls meanwhile
	always_comb begin
		ram_req       = '0;
		ram_req.waddr = cnt_q;
		ram_req.wdata = {fill_color_q, tcw_pkg::BLANK_CHAR};
		ram_req.raddr = cnt_q;
		if (cp_vld_s1) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = cp_addr_s1;
			ram_req.wdata = rd_data;
		end else if (state_q == S_FILL) begin
			ram_req.we = 1'b1;
		end else if (in_acc && req_type == tcw_pkg::REQ_PUT && !is_nl) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = cur_pos;
			ram_req.wdata = {text_color, char_code};
		end
		if (state_q == S_COPY) begin
			ram_req.re = 1'b1;
		end else if (in_acc && req_type == tcw_pkg::REQ_READ && idx_ok) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = AW'(cell_index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_FILL;
			init_q       <= 1'b1;
			cnt_q        <= '0;
			fill_color_q <= tcw_pkg::RESET_COLOR;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			scrolled_q   <= 1'b0;
			rd_q         <= '0;
			cp_vld_s1    <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == S_COPY);
			unique case (state_q)
				S_FILL: begin
					if (!cp_vld_s1) begin
						if (cnt_q == LAST_A) begin
							init_q  <= 1'b0;
							state_q <= init_q ? S_IDLE : S_DONE;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						scrolled_q <= 1'b0;
						rd_q       <= '0;
						unique case (req_type)
							tcw_pkg::REQ_PUT: begin
								cur_col_q <= put_col;
								cur_row_q <= put_row;
								if (put_scroll) begin
									scrolled_q   <= 1'b1;
									cnt_q        <= COLS_A;
									fill_color_q <= text_color;
									state_q      <= S_COPY;
								end else begin
									state_q <= S_DONE;
								end
							end
							tcw_pkg::REQ_CLEAR: begin
								cur_col_q    <= '0;
								cur_row_q    <= '0;
								cnt_q        <= '0;
								fill_color_q <= text_color;
								state_q      <= S_FILL;
							end
							tcw_pkg::REQ_READ: begin
								state_q <= idx_ok ? S_READ : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_COPY: begin
					if (cnt_q == LAST_A) begin
						cnt_q   <= TAIL_A;
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_READ: begin
					rd_q    <= rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a row move is pipelined: read at cnt, write in the next cycle one row up (cnt - COLS)
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q - COLS_A;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{cursor_col: cur_col_q, cursor_row: cur_row_q,
	                     scrolled: scrolled_q, read_cell: rd_q};

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_row_q) < tcw_pkg::ROWS)
		else $error("cursor row past bottom");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_col_q) < tcw_pkg::COLS)
		else $error("cursor column past line end");

	a_copy_wb: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (state_q == S_COPY || state_q == S_FILL))
		else $error("copy write-back outside scroll");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_DONE)
		else $error("read did not finish");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY |-> 32'(cur_row_q) == tcw_pkg::ROWS - 1 && scrolled_q)
		else $error("scroll without cursor on last row");

endmodule

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// Character-cell text console: an 80x25 screen of 16-bit cells (attribute in
// the high byte, character in the low byte) held in one synchronous RAM, plus
// a cursor. Every accepted word gives exactly one result word carrying the
// cursor after the step, a scrolled flag and, for a read, the cell value.
// The single RAM port pair serves one cell per cycle: a clear blanks all
// ROWS*COLS (2000) cells, and a put that scrolls copies every row below the
// top up one, then blanks the last row in the current color. After reset the
// block runs a blanking pass over all ROWS*COLS cells (color 0x0F) with
// in_stall high; text_color writes are taken at any time but should only be
// made while the block is idle. A finished result sits in an output register,
// so the next word can be taken while the previous result is still stalled.
module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CHAR_W-1:0]        cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::IDX_W-1:0]         cell_index,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcw_pkg::COL_W-1:0]         cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
	output logic                              scrolled,
	output logic [tcw_pkg::CELL_W-1:0]        read_cell
);

	logic [tcw_pkg::CHAR_W-1:0] text_color_q;
	logic                       idle;
	logic                       in_acc;
	tcw_pkg::ram_req_t          ram_req;
	logic [tcw_pkg::CELL_W-1:0] rd_data;
	logic                       res_valid;
	logic                       res_take;
	tcw_pkg::res_t              res;
	logic                       out_valid_q;
	tcw_pkg::res_t              out_q;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tcw_pkg::RESET_COLOR;
		end else if (cfg_we) begin
			text_color_q <= cfg_data;
		end
	end

	// one word in flight; take a new one only from idle
	assign in_stall = !idle;
	assign in_acc   = in_valid && idle;

	tcw_screen_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	tcw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.in_acc     (in_acc),
		.req_type   (req_type),
		.char_code  (char_code),
		.cell_index (cell_index),
		.idle       (idle),
		.ram_req    (ram_req),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// output register: loads when empty or being drained this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = out_q.cursor_col;
	assign cursor_row = out_q.cursor_row;
	assign scrolled   = out_q.scrolled;
	assign read_cell  = out_q.read_cell;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> !out_valid_q || !out_stall)
		else $error("result register overwritten");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second word taken while busy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	// request code the block must ignore (reports the cursor only)
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// cycles with no word moving on either channel before we give up;
	// the limit must outlast a full scroll or clear sweep
	localparam int QUIET_LIMIT = 12000;
	// cycles to keep watching for stray result words at the end
	localparam int TAIL_CYCLES = 12;
	// field widths used in casts
	localparam int CHW = tcw_pkg::CHAR_W;
	localparam int IW  = tcw_pkg::IDX_W;
	localparam int CLW = tcw_pkg::CELL_W;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_we     = 1'b0;
	logic [tcw_pkg::CHAR_W-1:0]   cfg_data   = tcw_pkg::RESET_COLOR;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [1:0]                   req_type   = tcw_pkg::REQ_PUT;
	logic [tcw_pkg::CHAR_W-1:0]   char_code  = '0;
	logic [tcw_pkg::IDX_W-1:0]    cell_index = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic [tcw_pkg::COL_W-1:0]    cursor_col;
	logic [tcw_pkg::ROW_W-1:0]    cursor_row;
	logic                         scrolled;
	logic [tcw_pkg::CELL_W-1:0]   read_cell;

	// behavioral copy of the console
	logic [tcw_pkg::CELL_W-1:0]   shadow_cells [0:tcw_pkg::CELLS-1];
	int                           pen_col;
	int                           pen_row;
	logic [tcw_pkg::CHAR_W-1:0]   ink;

	tcw_pkg::res_t                owed_results [$];
	tcw_pkg::res_t                due;
	int                           mismatches  = 0;
	int                           quiet_cycles = 0;
	int                           stall_left  = 0;
	bit                           idle_on     = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_console_writer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.scrolled   (scrolled),
		.read_cell  (read_cell)
	);

	// ---------------------------------------------------------------------
	// Console copy
	// ---------------------------------------------------------------------

	// Reset state: every cell a space in the reset color, cursor home.
	function automatic void blank_console();
		int i;
		for (i = 0; i < tcw_pkg::CELLS; i++)
			shadow_cells[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
		pen_col = 0;
		pen_row = 0;
		ink     = tcw_pkg::RESET_COLOR;
	endfunction

	// Apply one request word to the copy and return the result word it gives.
	function automatic tcw_pkg::res_t console_step(input logic [1:0] req,
			input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::IDX_W-1:0] idx);
		tcw_pkg::res_t r;
		int            i;
		r = '0;
		case (req)
			tcw_pkg::REQ_PUT: begin
				// a newline byte only moves the cursor, it is never stored
				if (ch == tcw_pkg::NEWLINE) begin
					pen_col = 0;
					pen_row++;
				end else begin
					shadow_cells[pen_row * tcw_pkg::COLS + pen_col] = {ink, ch};
					pen_col++;
					if (pen_col >= tcw_pkg::COLS) begin
						pen_col = 0;
						pen_row++;
					end
				end
				// ran off the bottom: move everything up a row, blank the last
				// row in the current color, stay on the last row
				if (pen_row >= tcw_pkg::ROWS) begin
					for (i = 0; i + tcw_pkg::COLS < tcw_pkg::CELLS; i++)
						shadow_cells[i] = shadow_cells[i + tcw_pkg::COLS];
					for (i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
						shadow_cells[i] = {ink, tcw_pkg::BLANK_CHAR};
					pen_row    = tcw_pkg::ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			tcw_pkg::REQ_CLEAR: begin
				for (i = 0; i < tcw_pkg::CELLS; i++)
					shadow_cells[i] = {ink, tcw_pkg::BLANK_CHAR};
				pen_col = 0;
				pen_row = 0;
			end
			tcw_pkg::REQ_READ: begin
				// indexes past the screen read as zero
				if (idx < tcw_pkg::CELLS)
					r.read_cell = shadow_cells[idx];
			end
			default: ;
		endcase
		r.cursor_col = pen_col[tcw_pkg::COL_W-1:0];
		r.cursor_row = pen_row[tcw_pkg::ROW_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	// Present one word and hold it until taken. Valid is left high on return,
	// so a back-to-back word only replaces the payload; whoever does something
	// else next drops valid in the same step.
	task automatic send_word(input logic [1:0] req, input logic [tcw_pkg::CHAR_W-1:0] ch,
			input logic [tcw_pkg::IDX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		char_code  <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		owed_results.push_back(console_step(req, ch, idx));
	endtask

	// Stop sending and wait until every owed result word is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	// Color changes only go in while the block is idle.
	task automatic set_color(input logic [tcw_pkg::CHAR_W-1:0] color);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= color;
		@(posedge clk);
		cfg_we   <= 1'b0;
		ink      = color;
	endtask

	// ---------------------------------------------------------------------
	// Result side: checker, stall bursts, watchdog
	// ---------------------------------------------------------------------

	task automatic note_mismatch(input string what, input logic [tcw_pkg::CELL_W-1:0] got,
			input logic [tcw_pkg::CELL_W-1:0] want);
		$display("%0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				note_mismatch("result word with nothing owed", read_cell, '0);
			end else begin
				due = owed_results.pop_front();
				if (cursor_col !== due.cursor_col)
					note_mismatch("cursor_col", CLW'(cursor_col), CLW'(due.cursor_col));
				if (cursor_row !== due.cursor_row)
					note_mismatch("cursor_row", CLW'(cursor_row), CLW'(due.cursor_row));
				if (scrolled !== due.scrolled)
					note_mismatch("scrolled", CLW'(scrolled), CLW'(due.scrolled));
				if (read_cell !== due.read_cell)
					note_mismatch("read_cell", read_cell, due.read_cell);
			end
		end
		// random stall bursts while idling is on
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		out_stall <= (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Freshly blanked screen, out of range reads, the unused request code.
	task automatic test_reset_screen();
		send_word(tcw_pkg::REQ_READ, 8'h00, 11'd0);
		send_word(tcw_pkg::REQ_READ, 8'hFF, IW'(tcw_pkg::CELLS - 1));
		send_word(tcw_pkg::REQ_READ, 8'h00, IW'(tcw_pkg::CELLS));
		send_word(tcw_pkg::REQ_READ, 8'hFF, 11'h7FF);
		send_word(REQ_UNUSED, 8'hFF, 11'h7FF);
	endtask

	// Extreme bytes in color 0x00, then a newline that must not be stored.
	task automatic test_put_newline();
		set_color(8'h00);
		send_word(tcw_pkg::REQ_PUT, 8'h00, 11'h7FF);
		send_word(tcw_pkg::REQ_PUT, 8'hFF, 11'd0);
		send_word(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE, 11'd0);
		send_word(tcw_pkg::REQ_PUT, 8'h41, 11'd0);
		send_word(tcw_pkg::REQ_READ, 8'h0A, 11'd0);
		send_word(tcw_pkg::REQ_READ, 8'h00, 11'd1);
		send_word(tcw_pkg::REQ_READ, 8'h00, 11'd2);
		send_word(tcw_pkg::REQ_READ, 8'h00, IW'(tcw_pkg::COLS));
	endtask

	// Clear in color 0xFF: whole screen blanks in that color, cursor home.
	task automatic test_clear_color();
		set_color(8'hFF);
		send_word(tcw_pkg::REQ_CLEAR, tcw_pkg::NEWLINE, 11'h7FF);
		send_word(tcw_pkg::REQ_READ, 8'h00, 11'd0);
		send_word(tcw_pkg::REQ_READ, 8'h00, IW'(tcw_pkg::CELLS - 1));
		send_word(REQ_UNUSED, 8'h00, 11'd0);
	endtask

	// Random text: mostly puts with a given newline share, reads that mostly
	// land near the cursor so written cells get read back, some clears and
	// unused codes. Idling switches on and off in stretches if allowed.
	task automatic test_random_text(input logic [tcw_pkg::CHAR_W-1:0] color,
			input int n_words, input int nl_pct, input bit allow_idle);
		int                          n;
		int                          pick;
		int                          spot;
		logic [tcw_pkg::CHAR_W-1:0]  ch;
		logic [tcw_pkg::IDX_W-1:0]   idx;
		set_color(color);
		for (n = 0; n < n_words; n++) begin
			if (n % 40 == 0)
				idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			ch   = CHW'($urandom_range(0, 255));
			idx  = IW'($urandom_range(0, 2047));
			if (pick < 70) begin
				// keep the newline share as asked, else never a newline
				if ($urandom_range(0, 99) < nl_pct)
					ch = tcw_pkg::NEWLINE;
				else if (ch == tcw_pkg::NEWLINE)
					ch = 8'h0B;
				send_word(tcw_pkg::REQ_PUT, ch, idx);
			end else if (pick < 92) begin
				spot = $urandom_range(0, 9);
				if (spot < 6) begin
					// current row, or the one above it
					if (pen_row > 0 && spot < 2)
						idx = IW'((pen_row - 1) * tcw_pkg::COLS +
							$urandom_range(0, tcw_pkg::COLS - 1));
					else
						idx = IW'(pen_row * tcw_pkg::COLS +
							$urandom_range(0, tcw_pkg::COLS - 1));
				end else if (spot < 9) begin
					idx = IW'($urandom_range(0, tcw_pkg::CELLS - 1));
				end
				send_word(tcw_pkg::REQ_READ, ch, idx);
			end else if (pick < 94) begin
				send_word(tcw_pkg::REQ_CLEAR, ch, idx);
			end else begin
				send_word(REQ_UNUSED, ch, idx);
			end
		end
	endtask

	initial begin
		blank_console();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_screen();
		test_put_newline();
		test_clear_color();

		test_random_text(CHW'($urandom_range(0, 255)), 307, 6, 1'b1);
		test_random_text(8'h00, 307, 2, 1'b1);
		test_random_text(8'hFF, 307, 15, 1'b1);
		test_random_text(CHW'($urandom_range(0, 255)), 307, 8, 1'b1);
		// closing phase at full rate, no gaps and no stalls
		test_random_text(CHW'($urandom_range(0, 255)), 307, 6, 1'b0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
